// ===== sv/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/q2e_pkg.sv =====
package q2e_pkg;

    localparam int TAB_LEN = 24;
    // cordic datapath width: operands reach about 2^31, growth bounded by 1.65
    localparam int CW = 36;
    // angle accumulator in 2^-16 degree
    localparam int AW = 26;
    localparam int QW = 16;
    localparam int OW = 17;

    localparam logic [1:0] CASE_GEN = 2'd0;
    localparam logic [1:0] CASE_POS = 2'd1;
    localparam logic [1:0] CASE_NEG = 2'd2;

    localparam logic signed [AW-1:0] DEG180 = AW'(180 * 65536);
    localparam logic signed [OW-1:0] FULL_TURN = OW'(46080);
    localparam logic signed [OW-1:0] QUARTER_TURN = OW'(11520);

    typedef logic signed [CW-1:0] cw_t;
    typedef logic signed [AW-1:0] ang_t;

    // one atan2 lane as it moves along the chain
    typedef struct packed {
        cw_t  xv;
        cw_t  yv;
        ang_t acc;
        logic fixed;
    } lane_t;

    // side data that travels alongside the lanes
    typedef struct packed {
        logic [1:0] kase;
        logic       ax_sat;
        logic       ax_neg;
    } side_t;

    function automatic ang_t atan_entry(input int i);
        ang_t r;
        case (i)
            0: r = AW'(2949120);
            1: r = AW'(1740967);
            2: r = AW'(919879);
            3: r = AW'(466945);
            4: r = AW'(234379);
            5: r = AW'(117304);
            6: r = AW'(58666);
            7: r = AW'(29335);
            8: r = AW'(14668);
            9: r = AW'(7334);
            10: r = AW'(3667);
            11: r = AW'(1833);
            12: r = AW'(917);
            13: r = AW'(458);
            14: r = AW'(229);
            15: r = AW'(115);
            16: r = AW'(57);
            17: r = AW'(29);
            18: r = AW'(14);
            19: r = AW'(7);
            20: r = AW'(4);
            21: r = AW'(2);
            22: r = AW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    // prepare a lane: zero and negative-x handling ahead of the rotations
    function automatic lane_t lane_init(input cw_t yv, input cw_t xv);
        lane_t l;
        l.fixed = 1'b0;
        l.acc = '0;
        l.xv = xv;
        l.yv = yv;
        if (yv == 0) begin
            l.fixed = 1'b1;
            l.acc = (xv < 0) ? DEG180 : ang_t'(0);
        end else if (xv < 0) begin
            l.acc = (yv > 0) ? DEG180 : -DEG180;
            l.xv = -xv;
            l.yv = -yv;
        end
        return l;
    endfunction

endpackage

// ===== sv/q2e_if.sv =====
interface q2e_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface q2e_out_if;
    logic valid;
    logic ready;
    logic signed [16:0] angle_x;
    logic signed [16:0] angle_y;
    logic signed [16:0] angle_z;
    logic [1:0] case_taken;
    modport source (output valid, angle_x, angle_y, angle_z, case_taken, input ready);
    modport sink (input valid, angle_x, angle_y, angle_z, case_taken, output ready);
endinterface

// ===== sv/q2e_cordic_cell.sv =====
module q2e_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   vin,
    input  q2e_pkg::lane_t [2:0]   lin,
    input  q2e_pkg::side_t         sin,
    output logic                   vout,
    output q2e_pkg::lane_t [2:0]   lout,
    output q2e_pkg::side_t         sout
);
    import q2e_pkg::*;

    localparam ang_t ATAN_I = atan_entry(STAGE);

    lane_t [2:0] lane_reg, lane_next;
    side_t side_reg;
    logic valid_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lane_next[k] = lin[k];
            if (!lin[k].fixed)
            begin
                if (lin[k].yv > 0)
                begin
                    lane_next[k].xv = lin[k].xv + (lin[k].yv >>> STAGE);
                    lane_next[k].yv = lin[k].yv - (lin[k].xv >>> STAGE);
                    lane_next[k].acc = lin[k].acc + ATAN_I;
                end
                else
                begin
                    lane_next[k].xv = lin[k].xv - (lin[k].yv >>> STAGE);
                    lane_next[k].yv = lin[k].yv + (lin[k].xv >>> STAGE);
                    lane_next[k].acc = lin[k].acc - ATAN_I;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
            side_reg <= sin;
        end
    end

    assign vout = valid_reg;
    assign lout = lane_reg;
    assign sout = side_reg;
endmodule

// ===== sv/q2e_front.sv =====
module q2e_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  vin,
    input  logic signed [15:0]    qx,
    input  logic signed [15:0]    qy,
    input  logic signed [15:0]    qz,
    input  logic signed [15:0]    qw,
    output logic                  vout,
    output q2e_pkg::lane_t [2:0]  lout,
    output q2e_pkg::side_t        sout
);
    import q2e_pkg::*;

    localparam logic signed [63:0] ONE_Q28 = 64'sd1 <<< 28;

    // stage 1: products
    logic signed [31:0] xx_reg, yy_reg, zz_reg, ww_reg, xw_reg, yz_reg;
    logic signed [31:0] wy_reg, zx_reg, wz_reg, xy_reg;
    logic signed [15:0] y1_reg, x1_reg;
    logic v1_reg;

    // stage 2: combined terms, case decision, s (squared at the root entry)
    logic signed [35:0] s_reg, yawy_reg, yawx_reg, roly_reg, rolx_reg;
    logic signed [15:0] y2_reg, x2_reg;
    logic [1:0] kase_reg;
    logic sat_reg, neg_reg, v2_reg;

    // isqrt pipeline: one result bit per stage, 29 stages over a 58-bit radicand
    localparam int SQ = 29;
    logic [57:0] rad_reg [0:SQ];
    logic [28:0] root_reg [0:SQ];
    logic [57:0] rem_reg [0:SQ];
    logic signed [35:0] sp_reg [0:SQ];
    logic signed [35:0] ayy_reg [0:SQ], ayx_reg [0:SQ], azy_reg [0:SQ], azx_reg [0:SQ];
    logic signed [15:0] py_reg [0:SQ], px_reg [0:SQ];
    side_t ps_reg [0:SQ];
    logic pv_reg [0:SQ];

    logic signed [63:0] unit_c, test_c, s_c;
    // |s| fits 28 bits whenever it is below one
    logic [27:0] s_mag_c;
    logic [55:0] sq_c;

    always_comb
    begin
        unit_c = 64'(xx_reg) + 64'(yy_reg) + 64'(zz_reg) + 64'(ww_reg);
        test_c = 64'(xw_reg) - 64'(yz_reg);
        s_c = test_c <<< 1;
        s_mag_c = 28'((s_reg < 0) ? -s_reg : s_reg);
        sq_c = s_mag_c * s_mag_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int i = 0; i <= SQ; i++)
                pv_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vin;
            v2_reg <= v1_reg;
            pv_reg[0] <= v2_reg;
            for (int i = 1; i <= SQ; i++)
                pv_reg[i] <= pv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            ww_reg <= qw * qw;
            xw_reg <= qx * qw;
            yz_reg <= qy * qz;
            wy_reg <= qw * qy;
            zx_reg <= qz * qx;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            y1_reg <= qy;
            x1_reg <= qx;

            if (test_c * 2000 > unit_c * 991)
                kase_reg <= CASE_POS;
            else if (test_c * 2000 < -(unit_c * 999))
                kase_reg <= CASE_NEG;
            else
                kase_reg <= CASE_GEN;
            sat_reg <= (s_c >= ONE_Q28) || (s_c <= -ONE_Q28);
            neg_reg <= s_c < 0;
            s_reg <= 36'(s_c);
            yawy_reg <= 36'((64'(wy_reg) + 64'(zx_reg)) <<< 1);
            yawx_reg <= 36'(ONE_Q28 - ((64'(xx_reg) + 64'(yy_reg)) <<< 1));
            roly_reg <= 36'((64'(wz_reg) + 64'(xy_reg)) <<< 1);
            rolx_reg <= 36'(ONE_Q28 - ((64'(zz_reg) + 64'(xx_reg)) <<< 1));
            y2_reg <= y1_reg;
            x2_reg <= x1_reg;

            // entry of the root chain; only meaningful when |s| < 1
            rad_reg[0] <= sat_reg ? 58'd0 : ({2'b01, 56'd0} - {2'b00, sq_c});
            root_reg[0] <= '0;
            rem_reg[0] <= '0;
            sp_reg[0] <= s_reg;
            ayy_reg[0] <= yawy_reg;
            ayx_reg[0] <= yawx_reg;
            azy_reg[0] <= roly_reg;
            azx_reg[0] <= rolx_reg;
            py_reg[0] <= y2_reg;
            px_reg[0] <= x2_reg;
            ps_reg[0] <= '{kase: kase_reg, ax_sat: sat_reg, ax_neg: neg_reg};

            for (int i = 1; i <= SQ; i++)
            begin
                logic [59:0] trial;
                logic [59:0] cur;
                cur = {rem_reg[i-1], rad_reg[i-1][57:56]};
                trial = {29'd0, root_reg[i-1], 2'b01};
                if (cur >= trial)
                begin
                    rem_reg[i] <= 58'(cur - trial);
                    root_reg[i] <= {root_reg[i-1][27:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= 58'(cur);
                    root_reg[i] <= {root_reg[i-1][27:0], 1'b0};
                end
                rad_reg[i] <= {rad_reg[i-1][55:0], 2'b00};
                sp_reg[i] <= sp_reg[i-1];
                ayy_reg[i] <= ayy_reg[i-1];
                ayx_reg[i] <= ayx_reg[i-1];
                azy_reg[i] <= azy_reg[i-1];
                azx_reg[i] <= azx_reg[i-1];
                py_reg[i] <= py_reg[i-1];
                px_reg[i] <= px_reg[i-1];
                ps_reg[i] <= ps_reg[i-1];
            end
        end
    end

    // lanes: 0 pitch (or singular yaw), 1 yaw, 2 roll
    always_comb
    begin
        if (ps_reg[SQ].kase != CASE_GEN)
            lout[0] = lane_init(cw_t'(py_reg[SQ]), cw_t'(px_reg[SQ]));
        else
            lout[0] = lane_init(cw_t'(sp_reg[SQ]), cw_t'({7'd0, root_reg[SQ]}));
        lout[1] = lane_init(cw_t'(ayy_reg[SQ]), cw_t'(ayx_reg[SQ]));
        lout[2] = lane_init(cw_t'(azy_reg[SQ]), cw_t'(azx_reg[SQ]));
    end

    assign sout = ps_reg[SQ];
    assign vout = pv_reg[SQ];
endmodule

// ===== sv/q2e_back.sv =====
module q2e_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  wrap,
    input  logic                  vin,
    input  q2e_pkg::lane_t [2:0]  lin,
    input  q2e_pkg::side_t        sin,
    output logic                  vout,
    output logic signed [16:0]    ax,
    output logic signed [16:0]    ay,
    output logic signed [16:0]    az,
    output logic [1:0]            kase
);
    import q2e_pkg::*;

    logic signed [OW-1:0] ax_reg, ay_reg, az_reg;
    logic [1:0] kase_reg;
    logic valid_reg;

    function automatic logic signed [OW-1:0] fin(input logic signed [OW-1:0] a,
                                                input logic w);
        logic signed [OW-1:0] r;
        r = a;
        if (w && r < 0)
            r = r + FULL_TURN;
        return r;
    endfunction

    function automatic logic signed [OW-1:0] rnd_fin(input ang_t a, input int s,
                                                    input logic neg, input logic w);
        ang_t c;
        logic signed [AW:0] t;
        logic signed [AW:0] r;
        c = (a > DEG180) ? DEG180 : ((a < -DEG180) ? -DEG180 : a);
        t = neg ? -(AW+1)'(c) : (AW+1)'(c);
        r = (t + ((AW+1)'(1) <<< (s - 1))) >>> s;
        return fin(OW'(r), w);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kase_reg <= sin.kase;
            if (sin.kase == CASE_POS)
            begin
                ax_reg <= QUARTER_TURN;
                ay_reg <= rnd_fin(lin[0].acc, 8, 1'b0, wrap);
                az_reg <= '0;
            end
            else if (sin.kase == CASE_NEG)
            begin
                ax_reg <= fin(-QUARTER_TURN, wrap);
                ay_reg <= rnd_fin(lin[0].acc, 8, 1'b1, wrap);
                az_reg <= '0;
            end
            else
            begin
                if (sin.ax_sat)
                    ax_reg <= fin(sin.ax_neg ? -QUARTER_TURN : QUARTER_TURN, wrap);
                else
                    ax_reg <= rnd_fin(lin[0].acc, 9, 1'b0, wrap);
                ay_reg <= rnd_fin(lin[1].acc, 9, 1'b0, wrap);
                az_reg <= rnd_fin(lin[2].acc, 9, 1'b0, wrap);
            end
        end
    end

    assign vout = valid_reg;
    assign ax = ax_reg;
    assign ay = ay_reg;
    assign az = az_reg;
    assign kase = kase_reg;
endmodule

// ===== sv/quaternion_to_euler_degrees_core.sv =====
// Quaternion (Q2.14) to Euler angles in 1/128 degree. Fully pipelined: one
// transaction is accepted every cycle while the pipe is not frozen. The pipe
// holds 3 front stages for products, combined terms and the root entry, 29
// square-root stages for the pitch asin, the CORDIC cell chain and one output
// stage. The whole pipe advances together and freezes only while a finished
// result is not taken.
`include "assert_macros.svh"

module quaternion_to_euler_degrees_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  logic wr_data,
    q2e_in_if.sink  in_ch,
    q2e_out_if.source out_ch
);
    import q2e_pkg::*;

    localparam int N = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

    logic wrap_reg;
    logic en;
    logic bvalid;

    logic vch [0:N];
    lane_t [2:0] lch [0:N];
    side_t sch [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wrap_reg <= 1'b0;
        else if (wr_en)
            wrap_reg <= wr_data;
    end

    assign en = !bvalid || out_ch.ready;
    assign in_ch.ready = en;

    q2e_front u_front (
        .clk(clk), .rst_n(rst_n), .en(en),
        .vin(in_ch.valid && in_ch.ready),
        .qx(in_ch.quat_x), .qy(in_ch.quat_y), .qz(in_ch.quat_z), .qw(in_ch.quat_w),
        .vout(vch[0]), .lout(lch[0]), .sout(sch[0])
    );

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        q2e_cordic_cell #(.STAGE(g)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .vin(vch[g]), .lin(lch[g]), .sin(sch[g]),
            .vout(vch[g+1]), .lout(lch[g+1]), .sout(sch[g+1])
        );
    end

    q2e_back u_back (
        .clk(clk), .rst_n(rst_n), .en(en), .wrap(wrap_reg),
        .vin(vch[N]), .lin(lch[N]), .sin(sch[N]),
        .vout(bvalid),
        .ax(out_ch.angle_x), .ay(out_ch.angle_y), .az(out_ch.angle_z),
        .kase(out_ch.case_taken)
    );

    assign out_ch.valid = bvalid;

    `ASSERT_IMPL(a_stall_holds, clk, rst_n, bvalid && !out_ch.ready, !in_ch.ready)
    `ASSERT_NEXT(a_result_kept, clk, rst_n, bvalid && !out_ch.ready, bvalid)
    `ASSERT_IMPL(a_singular_roll, clk, rst_n, bvalid && out_ch.case_taken != CASE_GEN, out_ch.angle_z == 0)
endmodule
